// ===== hw/rtl/lfdc_pkg.sv =====
// ----------------------------------------------------------------------------
// lfdc_pkg: line-follow drive control shared definitions
// Payload structs, operation and command codes, register indexes and reset
// values, and the power saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none

package lfdc_pkg;

   // field widths
   localparam int POS_W   = 32;
   localparam int POWER_W = 16;
   localparam int ADJ_W   = 15;
   localparam int DIST_W  = 31;
   localparam int CSR_W   = 31;
   localparam int CSR_IDX_W = 2;

   // operation codes
   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_START  = 2'd1;
   localparam logic [1:0] OP_CANCEL = 2'd2;

   // drive command codes
   localparam logic [1:0] CMD_NONE  = 2'd0;
   localparam logic [1:0] CMD_APPLY = 2'd1;
   localparam logic [1:0] CMD_STOP  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_BASE_POWER      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_STEER_ADJUST    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TARGET_DISTANCE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_STALL_THRESHOLD = 2'd3;

   // register reset values
   localparam logic signed [POWER_W-1:0] BASE_POWER_RST      = 16'sd8192;
   localparam logic [ADJ_W-1:0]          STEER_ADJUST_RST    = 15'd2048;
   localparam logic [DIST_W-1:0]         TARGET_DISTANCE_RST = 31'd6553600;
   localparam logic [DIST_W-1:0]         STALL_THRESHOLD_RST = 31'd65536;

   typedef struct packed {
      logic [1:0]              operation;
      logic signed [POS_W-1:0] position;
      logic                    line_seen;
      logic [2:0]              sensor_pattern;
   } req_type;

   typedef struct packed {
      logic signed [POWER_W-1:0] left_power;
      logic signed [POWER_W-1:0] right_power;
      logic [1:0]                drive_command;
      logic                      finished;
   } rsp_type;

   // clamp an 18-bit power sum into the 16-bit signed range
   function automatic logic signed [POWER_W-1:0] sat_power(input logic signed [17:0] v);
      logic signed [POWER_W-1:0] r;
      if (v > 18'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -18'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[POWER_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/line_follow_drive_control.sv =====
// Results are registered in the output stage. Each tick shifts the WINDOW_DEPTH-cell
// chain once. Throughput: one item per cycle while req_stall is low.
// The skid stage lets one more item in while a result is stalled at the output.
// Reset (synchronous): registers return to defaults, window valid bits,
//   origin and done flag clear; no clearing pass, items are taken at once.
// ----------------------------------------------------------------------------
// line_follow_drive_control: line-follow steering and finish detection
// Tracks odometer samples in a chain of window cells, detects stall and
// target travel, and derives steering powers from the light sensor pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module line_follow_drive_control
   import lfdc_pkg::*;
#(
   parameter int WINDOW_DEPTH = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire req_type              req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rsp_type                   rsp_data,
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata
);

   // configuration registers
   logic signed [POWER_W-1:0] base_power_ff;
   logic [ADJ_W-1:0]          steer_adjust_ff;
   logic [DIST_W-1:0]         target_distance_ff;
   logic [DIST_W-1:0]         stall_threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_power_ff      <= BASE_POWER_RST;
         steer_adjust_ff    <= STEER_ADJUST_RST;
         target_distance_ff <= TARGET_DISTANCE_RST;
         stall_threshold_ff <= STALL_THRESHOLD_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_BASE_POWER:      base_power_ff      <= csr_wdata[POWER_W-1:0];
            REG_STEER_ADJUST:    steer_adjust_ff    <= csr_wdata[ADJ_W-1:0];
            REG_TARGET_DISTANCE: target_distance_ff <= csr_wdata[DIST_W-1:0];
            REG_STALL_THRESHOLD: stall_threshold_ff <= csr_wdata[DIST_W-1:0];
            default: ;
         endcase
      end
   end

   logic accept;
   logic tick_acc;
   assign accept   = req_valid & ~req_stall;
   assign tick_acc = accept & (req_data.operation == OP_TICK);

   // position window: chain of cells, newest in cell 0
   logic signed [POS_W-1:0] cell_data [WINDOW_DEPTH];
   logic [WINDOW_DEPTH-1:0] cell_valid;

   genvar gi;
   generate
      for (gi = 0; gi < WINDOW_DEPTH; gi++) begin : g_cell
         if (gi == 0) begin : g_head
            lfdc_cell u_cell (
               .clock    (clock),
               .reset    (reset),
               .shift_en (tick_acc),
               .d_in     (req_data.position),
               .v_in     (1'b1),
               .d_out    (cell_data[gi]),
               .v_out    (cell_valid[gi])
            );
         end else begin : g_body
            lfdc_cell u_cell (
               .clock    (clock),
               .reset    (reset),
               .shift_en (tick_acc),
               .d_in     (cell_data[gi-1]),
               .v_in     (cell_valid[gi-1]),
               .d_out    (cell_data[gi]),
               .v_out    (cell_valid[gi])
            );
         end
      end
   endgenerate

   logic signed [POS_W-1:0] origin_ff, origin_in;
   logic                    done_ff, done_in;

   // stall test: after the shift the oldest entry is the one now in cell depth-2
   logic                    full_next;
   logic signed [POS_W-1:0] oldest;
   logic [POS_W:0]          moved;
   logic [POS_W:0]          moved_mag;
   logic                    stall_hit;

   assign full_next = cell_valid[WINDOW_DEPTH-2];
   assign oldest    = cell_data[WINDOW_DEPTH-2];
   assign moved     = {req_data.position[POS_W-1], req_data.position}
                    - {oldest[POS_W-1], oldest};
   assign moved_mag = moved[POS_W] ? (~moved + {{POS_W{1'b0}}, 1'b1}) : moved;
   assign stall_hit = full_next & (moved_mag < {2'b00, stall_threshold_ff});

   // travel from origin
   logic [POS_W:0] traveled;
   logic [POS_W:0] traveled_mag;
   logic           far_hit;

   assign traveled     = {req_data.position[POS_W-1], req_data.position}
                       - {origin_ff[POS_W-1], origin_ff};
   assign traveled_mag = traveled[POS_W] ? (~traveled + {{POS_W{1'b0}}, 1'b1}) : traveled;
   assign far_hit      = traveled_mag > {2'b00, target_distance_ff};

   // steering sums at 18 bits
   logic signed [17:0] base_w;
   logic signed [17:0] adj_w;
   logic signed [17:0] half_w;
   logic signed [17:0] left_sum;
   logic signed [17:0] right_sum;

   assign base_w = {{2{base_power_ff[POWER_W-1]}}, base_power_ff};
   assign adj_w  = {3'b000, steer_adjust_ff};
   assign half_w = {4'b0000, steer_adjust_ff[ADJ_W-1:1]};

   always_comb begin
      left_sum  = base_w;
      right_sum = base_w;
      priority if (req_data.sensor_pattern == 3'd1) begin
         left_sum  = base_w - adj_w;
         right_sum = base_w + adj_w;
      end else if (req_data.sensor_pattern == 3'd2) begin
         left_sum  = base_w + half_w;
         right_sum = base_w - half_w;
      end else if (req_data.sensor_pattern == 3'd4) begin
         left_sum  = base_w + adj_w;
         right_sum = base_w - adj_w;
      end else begin
         left_sum  = base_w;
         right_sum = base_w;
      end
   end

   // per-item decision
   rsp_type result;

   always_comb begin
      origin_in            = origin_ff;
      done_in              = done_ff;
      result.left_power    = '0;
      result.right_power   = '0;
      result.drive_command = CMD_NONE;
      unique case (req_data.operation)
         OP_START: begin
            origin_in = req_data.position;
            done_in   = 1'b0;
         end
         OP_CANCEL: begin
            done_in              = 1'b1;
            result.drive_command = CMD_STOP;
         end
         OP_TICK: begin
            if (done_ff) begin
               result.drive_command = CMD_STOP;
            end else if (stall_hit || far_hit) begin
               done_in = 1'b1;
            end else if (req_data.line_seen) begin
               result.left_power    = sat_power(left_sum);
               result.right_power   = sat_power(right_sum);
               result.drive_command = CMD_APPLY;
            end
         end
         default: ;
      endcase
      result.finished = done_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff <= '0;
         done_ff   <= 1'b0;
      end else if (accept) begin
         origin_ff <= origin_in;
         done_ff   <= done_in;
      end
   end

   // output register and skid stage
   lfdc_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_data   (result),
      .in_stall  (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef NO_ASSERTIONS
   // cancel always leaves the block done
   a_cancel_done: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.operation == OP_CANCEL) |=> done_ff)
      else $error("cancel did not set done");

   // start always clears done
   a_start_clear: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.operation == OP_START) |=> !done_ff)
      else $error("start did not clear done");

   // window valid bits fill from the newest end without gaps
   a_fill_prefix: assert property (@(posedge clock) disable iff (reset)
      $onehot({1'b0, cell_valid} + {{WINDOW_DEPTH{1'b0}}, 1'b1}))
      else $error("gap in window valid chain");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/lfdc_cell.sv =====
// ----------------------------------------------------------------------------
// lfdc_cell: one position window cell
// Holds one odometer sample and its valid bit; on a shift it takes the
// sample of its upstream neighbor and hands its own one downstream.
// ----------------------------------------------------------------------------
`default_nettype none

module lfdc_cell
   import lfdc_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    shift_en,
   input  wire logic signed [POS_W-1:0] d_in,
   input  wire logic                    v_in,
   output logic signed [POS_W-1:0]      d_out,
   output logic                         v_out
);

   logic signed [POS_W-1:0] data_ff;
   logic                    valid_ff;

   // sample storage, no reset needed
   always_ff @(posedge clock) begin
      if (shift_en) begin
         data_ff <= d_in;
      end
   end

   // valid bit, part of the fill tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (shift_en) begin
         valid_ff <= v_in;
      end
   end

   assign d_out = data_ff;
   assign v_out = valid_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/lfdc_out_buf.sv =====
// ----------------------------------------------------------------------------
// lfdc_out_buf: result output register with skid stage
// Registers each result and absorbs one extra transfer when the consumer
// stalls, so the upstream stall is a register output.
// ----------------------------------------------------------------------------
`default_nettype none

module lfdc_out_buf
   import lfdc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   input  wire rsp_type in_data,
   output logic         in_stall,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;
   logic    push;
   logic    pop;
   logic    main_free;

   assign in_stall  = skid_valid_ff;
   assign push      = in_valid & ~skid_valid_ff;
   assign pop       = main_valid_ff & ~rsp_stall;
   assign main_free = ~main_valid_ff | pop;

   // next state of both stages
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (main_free) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = in_data;
            main_valid_in = push;
         end
      end else if (push) begin
         skid_in       = in_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_ff;

`ifndef NO_ASSERTIONS
   // skid only holds data behind a waiting result
   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid stage filled with output stage empty");

   // skid fills only on a stalled output
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      (push && main_valid_ff && rsp_stall) |=> skid_valid_ff)
      else $error("stalled transfer not captured in skid stage");

   // a drained buffer with nothing arriving goes empty
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (pop && !skid_valid_ff && !push) |=> !main_valid_ff)
      else $error("result repeated after transfer");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: line-follow drive control regression
// Queue-fed driver and checking monitor around the block. A behavioral model
// of the steering and finish logic predicts every result at input transfer.
// Directed items cover the corners, then register settings change phase by
// phase under random traffic and random idling on both channels.
// ----------------------------------------------------------------------------

module tb_top;
   import lfdc_pkg::*;

   localparam int DEPTH        = 16;
   localparam int WATCHDOG_MAX = 4000;
   localparam int HOLDOFF_LEN  = 300;
   localparam int PHASE_ITEMS  = 235;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   line_follow_drive_control #(
      .WINDOW_DEPTH(DEPTH)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // model copy of the registers
   logic signed [POWER_W-1:0] cfg_base;
   logic [ADJ_W-1:0]          cfg_adjust;
   logic [DIST_W-1:0]         cfg_target;
   logic [DIST_W-1:0]         cfg_stall;

   // model copy of the drive state
   logic signed [POS_W-1:0] odo_window [DEPTH];
   int                      odo_fill;
   logic signed [POS_W-1:0] odo_origin;
   logic                    drive_done;

   req_type pending_req [$];
   rsp_type expected_rsp [$];
   int      queued_count  = 0;
   int      results_seen  = 0;
   int      error_count   = 0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   int      holdoff_serial = 0;
   int      holdoff_seen   = 0;
   int      holdoff_left   = 0;
   int      quiet_cycles   = 0;
   rsp_type want;

   task automatic flag_error(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   function automatic logic signed [POWER_W-1:0] clamp_power(input logic signed [17:0] v);
      logic signed [POWER_W-1:0] r;
      if (v > 18'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -18'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[POWER_W-1:0];
      end
      return r;
   endfunction

   // advance the drive model by one item and return the result it gives
   function automatic rsp_type predict_drive(input req_type r);
      rsp_type            o;
      logic signed [32:0] moved;
      logic signed [32:0] traveled;
      logic [32:0]        moved_mag;
      logic [32:0]        trav_mag;
      logic signed [17:0] lsum;
      logic signed [17:0] rsum;
      logic signed [17:0] adj_full;
      logic signed [17:0] adj_half;
      o = '0;
      case (r.operation)
         OP_START: begin
            odo_origin = r.position;
            drive_done = 1'b0;
         end
         OP_CANCEL: begin
            drive_done = 1'b1;
            o.drive_command = CMD_STOP;
         end
         OP_TICK: begin
            for (int i = DEPTH - 1; i > 0; i--) odo_window[i] = odo_window[i-1];
            odo_window[0] = r.position;
            if (odo_fill < DEPTH) odo_fill++;
            if (drive_done) begin
               o.drive_command = CMD_STOP;
            end else begin
               moved = {odo_window[0][31], odo_window[0]}
                     - {odo_window[odo_fill-1][31], odo_window[odo_fill-1]};
               traveled = {r.position[31], r.position} - {odo_origin[31], odo_origin};
               moved_mag = moved[32] ? (~moved + 33'd1) : moved;
               trav_mag = traveled[32] ? (~traveled + 33'd1) : traveled;
               if (odo_fill == DEPTH && moved_mag < {2'b00, cfg_stall}) begin
                  drive_done = 1'b1;
               end else if (trav_mag > {2'b00, cfg_target}) begin
                  drive_done = 1'b1;
               end else if (r.line_seen) begin
                  lsum = {{2{cfg_base[15]}}, cfg_base};
                  rsum = lsum;
                  adj_full = {3'd0, cfg_adjust};
                  adj_half = {4'd0, cfg_adjust[ADJ_W-1:1]};
                  case (r.sensor_pattern)
                     3'd1: begin
                        lsum = lsum - adj_full;
                        rsum = rsum + adj_full;
                     end
                     3'd2: begin
                        lsum = lsum + adj_half;
                        rsum = rsum - adj_half;
                     end
                     3'd4: begin
                        lsum = lsum + adj_full;
                        rsum = rsum - adj_full;
                     end
                     default: ;
                  endcase
                  o.left_power = clamp_power(lsum);
                  o.right_power = clamp_power(rsum);
                  o.drive_command = CMD_APPLY;
               end
            end
         end
         default: ;  // unused code: state untouched
      endcase
      o.finished = drive_done;
      return o;
   endfunction

   // request driver: new item once the previous one has transferred
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_rsp.push_back(predict_drive(req_data));
         end
         if (!req_valid || !req_stall) begin
            if (pending_req.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= pending_req.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_rsp.size() == 0) begin
               flag_error($sformatf("result with nothing expected: %h", rsp_data));
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.left_power !== want.left_power)
                  flag_error($sformatf("left_power got %0d want %0d",
                                       rsp_data.left_power, want.left_power));
               if (rsp_data.right_power !== want.right_power)
                  flag_error($sformatf("right_power got %0d want %0d",
                                       rsp_data.right_power, want.right_power));
               if (rsp_data.drive_command !== want.drive_command)
                  flag_error($sformatf("drive_command got %0d want %0d",
                                       rsp_data.drive_command, want.drive_command));
               if (rsp_data.finished !== want.finished)
                  flag_error($sformatf("finished got %0b want %0b",
                                       rsp_data.finished, want.finished));
            end
         end
         if (holdoff_seen != holdoff_serial) begin
            holdoff_seen = holdoff_serial;
            holdoff_left = HOLDOFF_LEN;
            rsp_stall <= 1'b1;
         end else if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // watchdog: no transfer on either channel for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_MAX);
            $display("line_follow_drive_control regression: fail");
            $finish;
         end
      end
   end

   task automatic queue_op(input logic [1:0] op, input logic [31:0] pos,
                           input logic line, input logic [2:0] pat);
      req_type r;
      r.operation = op;
      r.position = pos;
      r.line_seen = line;
      r.sensor_pattern = pat;
      pending_req.push_back(r);
      queued_count++;
   endtask

   // one drive action: start, a run of ticks, with some noise mixed in
   task automatic queue_run();
      logic [31:0] pos;
      logic [31:0] step;
      logic [31:0] step_max;
      bit          reverse;
      int          n;
      int          pick;
      pos = $urandom_range(3) == 0 ? {$urandom_range(1) ? 2'b10 : 2'b01, 30'd0} : $urandom;
      case ($urandom_range(5))
         0: step_max = 32'd0;
         1: step_max = 32'h0000_1000;
         2: step_max = 32'h0001_0000;
         3: step_max = 32'h0004_0000;
         4: step_max = 32'h0020_0000;
         default: step_max = 32'h8000_0000;
      endcase
      reverse = 1'($urandom_range(1));
      n = $urandom_range(40, 4);
      queue_op(OP_START, pos, 1'($urandom_range(1)), 3'($urandom_range(7)));
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(49);
         if (pick == 0) begin
            queue_op(OP_CANCEL, $urandom, 1'($urandom_range(1)), 3'($urandom_range(7)));
         end else if (pick == 1) begin
            queue_op(2'd3, $urandom, 1'($urandom_range(1)), 3'($urandom_range(7)));
         end else if (pick == 2) begin
            queue_op(2'($urandom_range(3)), $urandom, 1'($urandom_range(1)),
                     3'($urandom_range(7)));
         end else begin
            step = $urandom_range(step_max, 0);
            pos = reverse ? pos - step : pos + step;
            queue_op(OP_TICK, pos, $urandom_range(9) != 0, 3'($urandom_range(7)));
         end
      end
   endtask

   task automatic wait_drained();
      while (results_seen < queued_count) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic set_drive_regs(input logic signed [15:0] bp, input logic [14:0] adj,
                                 input logic [30:0] tgt, input logic [30:0] thr);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= REG_BASE_POWER;
      csr_wdata <= {15'd0, bp};
      @(posedge clock);
      csr_index <= REG_STEER_ADJUST;
      csr_wdata <= {16'd0, adj};
      @(posedge clock);
      csr_index <= REG_TARGET_DISTANCE;
      csr_wdata <= tgt;
      @(posedge clock);
      csr_index <= REG_STALL_THRESHOLD;
      csr_wdata <= thr;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cfg_base = bp;
      cfg_adjust = adj;
      cfg_target = tgt;
      cfg_stall = thr;
   endtask

   task automatic random_phase(input int count);
      int target_count;
      target_count = queued_count + count;
      while (queued_count < target_count) queue_run();
   endtask

   initial begin
      cfg_base = BASE_POWER_RST;
      cfg_adjust = STEER_ADJUST_RST;
      cfg_target = TARGET_DISTANCE_RST;
      cfg_stall = STALL_THRESHOLD_RST;
      for (int i = 0; i < DEPTH; i++) odo_window[i] = '0;
      odo_fill = 0;
      odo_origin = '0;
      drive_done = 1'b0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed corners under reset register values
      send_idle_pct = 34;
      recv_idle_pct = 71;
      queue_op(OP_TICK, 32'd0, 1'b1, 3'd1);              // tick straight out of reset
      queue_op(OP_START, 32'h8000_0000, 1'b0, 3'd0);     // most negative origin
      queue_op(OP_TICK, 32'h7FFF_FFFF, 1'b1, 3'd4);      // full-scale travel finishes
      queue_op(OP_TICK, 32'd0, 1'b1, 3'd4);              // already done: stop
      queue_op(OP_START, 32'd0, 1'b1, 3'd2);
      for (int k = 0; k < 8; k++)
         queue_op(OP_TICK, (k + 1) * 32'h0002_0000, 1'b1, k[2:0]);  // every pattern
      queue_op(OP_TICK, 32'h0012_0000, 1'b0, 3'd1);      // line lost
      queue_op(2'd3, 32'hFFFF_FFFF, 1'b1, 3'd7);         // unused operation
      queue_op(OP_CANCEL, 32'h5555_5555, 1'b1, 3'd1);
      queue_op(OP_TICK, 32'h0012_0000, 1'b1, 3'd1);      // tick after cancel: stop
      queue_op(OP_START, 32'd0, 1'b0, 3'd0);             // window is kept across start
      queue_op(OP_TICK, 32'h0014_0000, 1'b1, 3'd2);
      queue_op(OP_TICK, 32'h0014_0000, 1'b1, 3'd2);
      queue_op(OP_TICK, 32'h0000_8000, 1'b1, 3'd2);      // window full, stalled
      queue_op(OP_TICK, 32'h0000_8000, 1'b1, 3'd2);
      wait_drained();

      // random phases; sender idles less, then receiver idles less, then none
      set_drive_regs(16'sd8192, 15'd2048, 31'd6553600, 31'd65536);
      random_phase(PHASE_ITEMS);
      holdoff_serial++;   // long receiver hold-off to back the block up
      wait_drained();

      set_drive_regs(16'sd16384, 15'd16384, 31'h7FFF_FFFF, 31'd0);
      random_phase(PHASE_ITEMS);
      wait_drained();

      send_idle_pct = 71;
      recv_idle_pct = 34;
      set_drive_regs(-16'sd16384, 15'd16384, 31'd0, 31'h7FFF_FFFF);
      random_phase(PHASE_ITEMS);
      wait_drained();

      set_drive_regs(16'sd0, 15'd0, 31'($urandom_range(32'h0100_0000, 0)),
                     31'($urandom_range(32'h0010_0000, 0)));
      random_phase(PHASE_ITEMS);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_drive_regs(16'($urandom_range(32768, 0) - 16384), 15'($urandom_range(16384, 0)),
                     31'($urandom_range(32'h0400_0000, 0)),
                     31'($urandom_range(32'h0004_0000, 0)));
      random_phase(PHASE_ITEMS);
      wait_drained();

      set_drive_regs(16'($urandom_range(32768, 0) - 16384), 15'($urandom_range(16384, 0)),
                     31'($urandom_range(32'h7FFF_FFFF, 0)),
                     31'($urandom_range(32'h0002_0000, 0)));
      random_phase(PHASE_ITEMS);
      wait_drained();

      if (expected_rsp.size() != 0)
         flag_error($sformatf("%0d results never arrived", expected_rsp.size()));
      if (error_count == 0) begin
         $display("line_follow_drive_control regression: pass");
      end else begin
         $display("line_follow_drive_control regression: fail");
      end
      $finish;
   end

endmodule
